/* rtl/hll_pkg.sv */
package hll_pkg;

  localparam int unsigned HASH_W = 32;
  localparam int unsigned RANK_W = 5;
  localparam int unsigned SUM_W  = 43;
  localparam int unsigned ZCNT_W = 11;
  localparam int unsigned TERM_W = HASH_W + 1;

  typedef enum logic [1:0] {
    KIND_ADD   = 2'd0,
    KIND_CLEAR = 2'd1,
    KIND_QUERY = 2'd2
  } kind_e;

  typedef logic [RANK_W-1:0] rank_t;

endpackage

/* rtl/hll_rank.sv */
module hll_rank import hll_pkg::*; #(
  parameter int unsigned REST_W = 22
) (
  input  logic [REST_W-1:0] rest_i,
  output rank_t             rank_o
);

  // Priority encoder: the highest set bit wins. With no bit set the rank is
  // one past the width of the remaining hash bits.
  always_comb begin
    rank_o = RANK_W'(REST_W + 1);
    for (int i = 0; i < int'(REST_W); i++) begin
      if (rest_i[i]) begin
        rank_o = RANK_W'(int'(REST_W) - i);
      end
    end
  end

endmodule

/* rtl/hyperloglog_register_sketch_core.sv */
// HyperLogLog register sketch with 2^INDEX_BITS five-bit rank registers kept
// in one single-port-write, registered-read memory. Add transactions are taken
// one per cycle while in_stall_o is low: the rank is computed on entry, the
// register is read at the accepting edge and the larger value is written back
// at the following edge, with a bypass from the previous write when two adds
// in a row hit the same register. A clear transaction writes zero to every
// register, one per cycle, and holds in_stall_o high until that pass is done.
// A query transaction reads every register, one per cycle, and presents the
// harmonic sum (scaled by 2^32) and the zero count once the scan is done and
// the output register is free; input is stalled until then. After reset the
// same zeroing pass runs before the first transaction is accepted. Kind code 3
// is accepted and ignored. harmonic_sum_o is exact for INDEX_BITS up to 10
// and wraps modulo 2^43 above that.
module hyperloglog_register_sketch_core import hll_pkg::*; #(
  parameter int unsigned INDEX_BITS = 10
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  logic [1:0]          kind_i,
  input  logic [HASH_W-1:0]   hash_value_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output logic [SUM_W-1:0]    harmonic_sum_o,
  output logic [ZCNT_W-1:0]   zero_count_o
);

  localparam int unsigned DEPTH  = 1 << INDEX_BITS;
  localparam int unsigned REST_W = HASH_W - INDEX_BITS;

  localparam logic [1:0] ST_CLR  = 2'd0;
  localparam logic [1:0] ST_IDLE = 2'd1;
  localparam logic [1:0] ST_SCAN = 2'd2;
  localparam logic [1:0] ST_FIN  = 2'd3;

  localparam logic [INDEX_BITS-1:0] LAST_IDX = {INDEX_BITS{1'b1}};

  logic [1:0]            state_q, state_d;
  logic [INDEX_BITS-1:0] cnt_q, cnt_d;

  rank_t                 mem [DEPTH];
  rank_t                 rdata_q;
  logic [INDEX_BITS-1:0] rd_addr;
  logic                  wr_en;
  logic [INDEX_BITS-1:0] wr_addr;
  rank_t                 wr_data;

  logic                  s1_vld_q;
  logic [INDEX_BITS-1:0] s1_idx_q;
  rank_t                 s1_rank_q;
  rank_t                 in_rank;
  rank_t                 old_rank;
  rank_t                 new_rank;

  logic                  fwd_vld_q;
  logic [INDEX_BITS-1:0] fwd_idx_q;
  rank_t                 fwd_dat_q;

  logic                  sc_vld_q;
  logic [SUM_W-1:0]      sum_q, sum_d;
  logic [ZCNT_W-1:0]     zc_q, zc_d;
  logic [TERM_W-1:0]     term;

  logic                  in_acc;
  logic                  add_acc;
  logic                  query_acc;
  logic                  clear_acc;
  logic                  out_load;

  assign in_stall_o = (state_q != ST_IDLE);
  assign in_acc     = in_valid_i && !in_stall_o;
  assign add_acc    = in_acc && (kind_i == KIND_ADD);
  assign clear_acc  = in_acc && (kind_i == KIND_CLEAR);
  assign query_acc  = in_acc && (kind_i == KIND_QUERY);

  hll_rank #(
    .REST_W (REST_W)
  ) u_rank (
    .rest_i (hash_value_i[REST_W-1:0]),
    .rank_o (in_rank)
  );

  // Read-modify-write. The register read at the accepting edge may be stale if
  // the add just before it wrote the same register at that edge.
  assign old_rank = (fwd_vld_q && (fwd_idx_q == s1_idx_q)) ? fwd_dat_q : rdata_q;
  assign new_rank = (s1_rank_q > old_rank) ? s1_rank_q : old_rank;

  assign rd_addr = (state_q == ST_IDLE) ? hash_value_i[HASH_W-1 -: INDEX_BITS] : cnt_q;
  assign wr_en   = (state_q == ST_CLR) || s1_vld_q;
  assign wr_addr = (state_q == ST_CLR) ? cnt_q : s1_idx_q;
  assign wr_data = (state_q == ST_CLR) ? '0 : new_rank;

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rdata_q <= mem[rd_addr];
  end

  // Summary accumulation over the scan.
  assign term = {1'b1, {HASH_W{1'b0}}} >> rdata_q;
  assign out_load = (state_q == ST_FIN) && !sc_vld_q && (!out_valid_o || !out_stall_i);

  always_comb begin
    sum_d = sum_q;
    zc_d  = zc_q;
    if (query_acc) begin
      sum_d = '0;
      zc_d  = '0;
    end else if (sc_vld_q) begin
      sum_d = sum_q + SUM_W'(term);
      zc_d  = zc_q + ZCNT_W'(rdata_q == '0);
    end
  end

  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    case (state_q)
      ST_CLR: begin
        cnt_d = cnt_q + 1'b1;
        if (cnt_q == LAST_IDX) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        cnt_d = '0;
        if (clear_acc) begin
          state_d = ST_CLR;
        end else if (query_acc) begin
          state_d = ST_SCAN;
        end
      end
      ST_SCAN: begin
        cnt_d = cnt_q + 1'b1;
        if (cnt_q == LAST_IDX) begin
          state_d = ST_FIN;
        end
      end
      ST_FIN: begin
        if (out_load) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLR;
      cnt_q       <= '0;
      s1_vld_q    <= 1'b0;
      fwd_vld_q   <= 1'b0;
      sc_vld_q    <= 1'b0;
      out_valid_o <= 1'b0;
    end else begin
      state_q   <= state_d;
      cnt_q     <= cnt_d;
      s1_vld_q  <= add_acc;
      fwd_vld_q <= s1_vld_q;
      sc_vld_q  <= (state_q == ST_SCAN);
      if (out_load) begin
        out_valid_o <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_o <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (add_acc) begin
      s1_idx_q  <= hash_value_i[HASH_W-1 -: INDEX_BITS];
      s1_rank_q <= in_rank;
    end
    fwd_idx_q <= s1_idx_q;
    fwd_dat_q <= new_rank;
    sum_q     <= sum_d;
    zc_q      <= zc_d;
    if (out_load) begin
      harmonic_sum_o <= sum_q;
      zero_count_o   <= zc_q;
    end
  end

endmodule

/* bench/hyperloglog_register_sketch_core_test.sv */
module hyperloglog_register_sketch_core_test;
  import hll_pkg::*;

  localparam int unsigned IDX          = 10;
  localparam int unsigned SKETCH_SIZE  = 1 << IDX;
  localparam int unsigned REST_W       = HASH_W - IDX;
  localparam int unsigned HOLD_CYCLES  = 3000;
  localparam longint      LIMIT_CYCLES = 1_500_000;
  localparam logic [1:0]  KIND_UNUSED  = 2'd3;

  typedef struct packed {
    logic [SUM_W-1:0]  harmonic_sum;
    logic [ZCNT_W-1:0] zero_count;
  } summary_t;

  logic              clk_i = 1'b0;
  logic              rst_ni = 1'b0;
  logic              in_valid_i = 1'b0;
  logic              in_stall_o;
  logic [1:0]        kind_i = KIND_ADD;
  logic [HASH_W-1:0] hash_value_i = '0;
  logic              out_valid_o;
  logic              out_stall_i = 1'b0;
  logic [SUM_W-1:0]  harmonic_sum_o;
  logic [ZCNT_W-1:0] zero_count_o;

  rank_t    sketch_regs [SKETCH_SIZE];
  summary_t pending_summaries [$];

  int unsigned send_idle_pct = 0;
  int unsigned rcv_idle_pct = 0;
  int unsigned mismatch_count = 0;
  int unsigned n_adds = 0;
  int unsigned n_clears = 0;
  int unsigned n_queries = 0;
  int unsigned n_ignored = 0;
  int unsigned n_checked = 0;
  logic        hold_toggle = 1'b0;
  logic        hold_seen = 1'b0;
  int unsigned hold_left = 0;

  hyperloglog_register_sketch_core #(
    .INDEX_BITS(IDX)
  ) uut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .kind_i        (kind_i),
    .hash_value_i  (hash_value_i),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .harmonic_sum_o(harmonic_sum_o),
    .zero_count_o  (zero_count_o)
  );

  always #6 clk_i = ~clk_i;

  function automatic rank_t hash_rank(input logic [HASH_W-1:0] h);
    logic [HASH_W-1:0] rest;
    int unsigned       lz;
    bit                found;
    rest = h << IDX;
    lz = 0;
    found = 1'b0;
    if (rest == '0) return rank_t'(HASH_W - IDX + 1);
    for (int b = HASH_W - 1; b >= 0; b--) begin
      if (!found && rest[b]) found = 1'b1;
      else if (!found) lz++;
    end
    return rank_t'(lz + 1);
  endfunction

  function automatic summary_t sketch_summary();
    logic [63:0] sum;
    logic [31:0] zeros;
    summary_t    s;
    sum = '0;
    zeros = '0;
    for (int i = 0; i < SKETCH_SIZE; i++) begin
      if (sketch_regs[i] == '0) zeros++;
      sum += 64'd1 << (HASH_W - sketch_regs[i]);
    end
    s.harmonic_sum = sum[SUM_W-1:0];
    s.zero_count = zeros[ZCNT_W-1:0];
    return s;
  endfunction

  // Mirrors the effect of one accepted transaction on the sketch.
  task automatic sketch_apply(input logic [1:0] k, input logic [HASH_W-1:0] h);
    int unsigned slot;
    rank_t       r;
    case (k)
      KIND_ADD: begin
        slot = h >> REST_W;
        r = hash_rank(h);
        if (r > sketch_regs[slot]) sketch_regs[slot] = r;
        n_adds++;
      end
      KIND_CLEAR: begin
        foreach (sketch_regs[i]) sketch_regs[i] = '0;
        n_clears++;
      end
      KIND_QUERY: begin
        pending_summaries.push_back(sketch_summary());
        n_queries++;
      end
      default: n_ignored++;
    endcase
  endtask

  task automatic note_mismatch(input string msg);
    mismatch_count++;
    if (mismatch_count <= 10) $display("mismatch: %s", msg);
  endtask

  // Offers one transaction, waits for it to be taken, then maybe idles.
  task automatic send_item(input logic [1:0] k, input logic [HASH_W-1:0] h);
    in_valid_i <= 1'b1;
    kind_i <= k;
    hash_value_i <= h;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    sketch_apply(k, h);
    if ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      kind_i <= 2'($urandom);
      hash_value_i <= $urandom;
      @(posedge clk_i);
      while ($urandom_range(99) < send_idle_pct) @(posedge clk_i);
    end
  endtask

  function automatic logic [HASH_W-1:0] rank_hash(input int unsigned slot,
                                                  input int unsigned rank);
    logic [HASH_W-1:0] rest;
    rest = (rank > REST_W) ? '0 : (32'd1 << (REST_W - rank));
    return (HASH_W'(slot) << REST_W) | rest;
  endfunction

  // Hashes biased toward a few hot registers and toward long zero runs.
  function automatic logic [HASH_W-1:0] random_hash();
    logic [HASH_W-1:0] slot;
    logic [HASH_W-1:0] rest;
    int unsigned       sel;
    sel = $urandom_range(99);
    slot = (sel < 30) ? $urandom_range(3) : ($urandom & (SKETCH_SIZE - 1));
    sel = $urandom_range(99);
    if (sel < 10) rest = '0;
    else if (sel < 55) rest = $urandom >> $urandom_range(31);
    else rest = $urandom;
    return (slot << REST_W) | (rest & (32'hFFFF_FFFF >> IDX));
  endfunction

  always @(posedge clk_i) begin
    summary_t exp;
    if (out_valid_o && !out_stall_i) begin
      if (pending_summaries.size() == 0) begin
        note_mismatch($sformatf("summary sum=%0d zeros=%0d with no query pending",
                                harmonic_sum_o, zero_count_o));
      end else begin
        exp = pending_summaries.pop_front();
        n_checked++;
        if (harmonic_sum_o !== exp.harmonic_sum)
          note_mismatch($sformatf("harmonic_sum expected %0d got %0d",
                                  exp.harmonic_sum, harmonic_sum_o));
        if (zero_count_o !== exp.zero_count)
          note_mismatch($sformatf("zero_count expected %0d got %0d",
                                  exp.zero_count, zero_count_o));
      end
    end
  end

  // Receiver: random holds, or one long hold counted down when requested.
  always @(posedge clk_i) begin
    if (hold_toggle != hold_seen) begin
      hold_seen = hold_toggle;
      hold_left = HOLD_CYCLES;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_stall_i <= 1'b1;
    end else begin
      out_stall_i <= ($urandom_range(99) < rcv_idle_pct);
    end
  end

  task automatic test_reset_state();
    send_item(KIND_QUERY, $urandom);
  endtask

  task automatic test_rank_extremes();
    send_item(KIND_ADD, 32'h0000_0000);
    send_item(KIND_ADD, 32'hFFFF_FFFF);
    send_item(KIND_ADD, rank_hash(SKETCH_SIZE - 1, REST_W));
    send_item(KIND_ADD, rank_hash(0, 1));
    send_item(KIND_ADD, rank_hash(SKETCH_SIZE / 2, REST_W + 1));
    send_item(KIND_QUERY, 32'hFFFF_FFFF);
  endtask

  // Same-register adds exercise the RMW bypass when sent back to back.
  task automatic test_same_register_runs();
    send_item(KIND_ADD, rank_hash(5, 3));
    send_item(KIND_ADD, rank_hash(5, 7));
    send_item(KIND_ADD, rank_hash(5, 2));
    send_item(KIND_ADD, rank_hash(5, 7));
    send_item(KIND_ADD, rank_hash(5, 12));
    send_item(KIND_QUERY, '0);
  endtask

  task automatic test_ignored_kind();
    send_item(KIND_UNUSED, 32'h0000_0000);
    send_item(KIND_UNUSED, 32'hFFFF_FFFF);
    send_item(KIND_QUERY, $urandom);
  endtask

  task automatic test_clear();
    send_item(KIND_CLEAR, 32'hFFFF_FFFF);
    send_item(KIND_QUERY, '0);
    send_item(KIND_ADD, random_hash());
    send_item(KIND_CLEAR, '0);
    send_item(KIND_CLEAR, $urandom);
    send_item(KIND_QUERY, $urandom);
  endtask

  task automatic test_random_mix(input int unsigned count);
    int unsigned sel;
    for (int n = 0; n < count; n++) begin
      sel = $urandom_range(99);
      if (sel < 8) send_item(KIND_QUERY, $urandom);
      else if (sel < 11) send_item(KIND_CLEAR, $urandom);
      else if (sel < 15) send_item(KIND_UNUSED, $urandom);
      else send_item(KIND_ADD, random_hash());
    end
  endtask

  // The receiver holds off while queries keep coming, so the block backs up.
  task automatic test_output_backpressure();
    hold_toggle <= ~hold_toggle;
    for (int q = 0; q < 3; q++) begin
      send_item(KIND_QUERY, $urandom);
      for (int n = 0; n < 20; n++) send_item(KIND_ADD, random_hash());
    end
  endtask

  // Touching every register drives the zero count down to nothing.
  task automatic test_fill_all();
    for (int i = 0; i < SKETCH_SIZE; i++)
      send_item(KIND_ADD, (HASH_W'(i) << REST_W) | ($urandom >> (IDX + $urandom_range(22))));
    send_item(KIND_QUERY, $urandom);
  endtask

  initial begin
    foreach (sketch_regs[i]) sketch_regs[i] = '0;
    send_idle_pct = 32;
    rcv_idle_pct = 48;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;

    test_reset_state();
    test_rank_extremes();
    test_same_register_runs();
    test_ignored_kind();
    test_clear();
    test_random_mix(160);

    send_idle_pct = 48;
    rcv_idle_pct = 32;
    test_random_mix(160);
    test_output_backpressure();

    send_idle_pct = 0;
    rcv_idle_pct = 0;
    test_random_mix(160);
    test_fill_all();
    in_valid_i <= 1'b0;

    while (pending_summaries.size() != 0) @(posedge clk_i);
    repeat (2 * SKETCH_SIZE + 16) @(posedge clk_i);

    $display("covered %0d adds, %0d clears, %0d queries, %0d unused-kind transactions",
             n_adds, n_clears, n_queries, n_ignored);
    $display("%0d summaries compared, %0d mismatches", n_checked, mismatch_count);
    if (mismatch_count == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

  initial begin
    #(LIMIT_CYCLES * 12);
    $display("timeout with %0d summaries outstanding", pending_summaries.size());
    $display("CHECK FAILED");
    $finish;
  end

endmodule
